// ===== hdl/awi_pkg.sv =====
// ----------------------------------------------------------------------------
// Affine warp interpolator package
// Shared constants and the configuration register map.
// ----------------------------------------------------------------------------
package awi_pkg;

    localparam int DEF_SRC_WIDTH  = 128;
    localparam int DEF_SRC_HEIGHT = 128;
    localparam int FRAC_BITS      = 16;
    localparam int COEF_W         = 24;
    localparam int OFFS_W         = 32;
    localparam int POS_W          = 12;
    localparam int CHAN_W         = 8;
    localparam int PIX_W          = 3 * CHAN_W;
    localparam int ACC_W          = 40;
    localparam int PROD_W         = COEF_W + POS_W + 1;
    localparam int FRAC1_W        = FRAC_BITS + 1;
    localparam int WGT_W          = 2 * FRAC_BITS + 1;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_IDX_W      = 3;

    localparam logic [FRAC1_W-1:0] ONE_Q16  = FRAC1_W'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] HALF_Q16 = FRAC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [WGT_W-1:0]   WGT_ONE  = WGT_W'(1) << (2 * FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_XX  = 3'd0,
        CFG_COEF_XY  = 3'd1,
        CFG_OFFSET_X = 3'd2,
        CFG_COEF_YX  = 3'd3,
        CFG_COEF_YY  = 3'd4,
        CFG_OFFSET_Y = 3'd5,
        CFG_MODE     = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        MODE_BILINEAR = 1'b0,
        MODE_NEAREST  = 1'b1
    } t_mode;

    typedef enum logic {
        ACT_WRITE   = 1'b0,
        ACT_REQUEST = 1'b1
    } t_action;

endpackage

// ===== hdl/affine_warp_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// Affine warp interpolator core
// Backward-mapping affine warp with bilinear or nearest sampling from a
// frame store split into four banks by column and row parity.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_stall    action, pos_x, pos_y, in_rgb
//   output    out        o_valid / i_stall    out_rgb, inside_res
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One request enters per cycle while o_stall is low; writes yield no result.
// The matrix multiply, the bank read and the weight multiplies set the depth.
// Reset loads an identity matrix in bilinear mode and clears all valid bits;
// the frame store is not cleared. An output stall freezes the whole pipeline.
// ----------------------------------------------------------------------------
module affine_warp_interpolator_core
    import awi_pkg::*;
#(
    parameter int SRC_WIDTH  = DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT = DEF_SRC_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_action,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [CHAN_W-1:0]     i_in_red,
    input  logic [CHAN_W-1:0]     i_in_green,
    input  logic [CHAN_W-1:0]     i_in_blue,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CHAN_W-1:0]     o_out_red,
    output logic [CHAN_W-1:0]     o_out_green,
    output logic [CHAN_W-1:0]     o_out_blue,
    output logic                  o_inside_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IXW = $clog2(SRC_WIDTH);
    localparam int IYW = $clog2(SRC_HEIGHT);
    localparam int XAW = IXW + 1;
    localparam int YAW = IYW + 1;
    localparam int XB  = ($clog2((SRC_WIDTH + 1) / 2) > 0) ? $clog2((SRC_WIDTH + 1) / 2) : 1;
    localparam int YB  = ($clog2((SRC_HEIGHT + 1) / 2) > 0) ? $clog2((SRC_HEIGHT + 1) / 2) : 1;
    localparam int BANK_DEPTH = 1 << (XB + YB);
    localparam int BAW = XB + YB;
    localparam logic [ACC_W-1:0] LIM_X = ACC_W'(SRC_WIDTH) << FRAC_BITS;
    localparam logic [ACC_W-1:0] LIM_Y = ACC_W'(SRC_HEIGHT) << FRAC_BITS;
    localparam int MUL_W = WGT_W + CHAN_W;

    logic en;

    logic signed [COEF_W-1:0] r_coef_xx, r_coef_xy, r_coef_yx, r_coef_yy;
    logic signed [OFFS_W-1:0] r_offset_x, r_offset_y;
    logic                     r_mode;

    // Stage 1: input register.
    logic                 r1_v, r1_req;
    logic [POS_W-1:0]     r1_x, r1_y;
    logic [PIX_W-1:0]     r1_pix;
    // Stage 2: matrix products.
    logic                 r2_v, r2_req;
    logic [POS_W-1:0]     r2_x, r2_y;
    logic [PIX_W-1:0]     r2_pix;
    logic signed [PROD_W-1:0] r2_pxx, r2_pxy, r2_pyx, r2_pyy;
    // Stage 3: mapped coordinate.
    logic                 r3_v, r3_req;
    logic [POS_W-1:0]     r3_x, r3_y;
    logic [PIX_W-1:0]     r3_pix;
    logic signed [ACC_W-1:0] r3_sx, r3_sy;
    // Stage 4: bank read data and sample geometry.
    logic                 r4_v, r4_req, r4_inside, r4_ix0, r4_iy0;
    logic [FRAC_BITS-1:0] r4_fx, r4_fy;
    logic [3:0]           r4_zero;
    logic [1:0]           r4_near;
    // Stage 5: weights and neighbor pixels.
    logic                 r5_v, r5_req, r5_inside;
    logic [WGT_W-1:0]     r5_w   [4];
    logic [PIX_W-1:0]     r5_pix [4];
    // Stage 6: weighted channels.
    logic                 r6_v, r6_req, r6_inside;
    logic [MUL_W-1:0]     r6_prod [4][3];
    // Stage 7: output register.
    logic                 r_ov, r_oinside;
    logic [CHAN_W-1:0]    r_ored, r_ogreen, r_oblue;

    logic                 n_inside;
    logic [IXW-1:0]       n_ix;
    logic [IYW-1:0]       n_iy;
    logic [XAW-1:0]       n_xa [2];
    logic [YAW-1:0]       n_ya [2];
    logic [BAW-1:0]       n_raddr [4];
    logic [3:0]           n_zero;
    logic [3:0]           n_we;
    logic [BAW-1:0]       n_waddr;
    logic                 n_wr_ok;
    logic [PIX_W-1:0]     w_rdata [4];
    logic [WGT_W-1:0]     n_w   [4];
    logic [PIX_W-1:0]     n_pix [4];
    logic [FRAC1_W-1:0]   n_wx, n_wy;
    logic [MUL_W+1:0]     n_sum [3];

    assign en      = !r_ov || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx  <= COEF_W'(ONE_Q16);
            r_coef_xy  <= '0;
            r_offset_x <= '0;
            r_coef_yx  <= '0;
            r_coef_yy  <= COEF_W'(ONE_Q16);
            r_offset_y <= '0;
            r_mode     <= MODE_BILINEAR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COEF_XX:  r_coef_xx  <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_XY:  r_coef_xy  <= i_cfg_data[COEF_W-1:0];
                CFG_OFFSET_X: r_offset_x <= i_cfg_data[OFFS_W-1:0];
                CFG_COEF_YX:  r_coef_yx  <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_YY:  r_coef_yy  <= i_cfg_data[COEF_W-1:0];
                CFG_OFFSET_Y: r_offset_y <= i_cfg_data[OFFS_W-1:0];
                CFG_MODE:     r_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_inside = !r3_sx[ACC_W-1] && !r3_sy[ACC_W-1] &&
                   (r3_sx < $signed(LIM_X)) && (r3_sy < $signed(LIM_Y));
        n_ix = r3_sx[FRAC_BITS +: IXW];
        n_iy = r3_sy[FRAC_BITS +: IYW];
        for (int b = 0; b < 2; b++) begin
            n_xa[b] = (n_ix[0] == b[0]) ? {1'b0, n_ix} : XAW'(n_ix) + XAW'(1);
            n_ya[b] = (n_iy[0] == b[0]) ? {1'b0, n_iy} : YAW'(n_iy) + YAW'(1);
        end
        for (int b = 0; b < 4; b++) begin
            n_raddr[b] = {n_ya[b/2][YB:1], n_xa[b%2][XB:1]};
            n_zero[b]  = (n_xa[b%2] == XAW'(SRC_WIDTH)) || (n_ya[b/2] == YAW'(SRC_HEIGHT));
        end
        n_wr_ok = r3_v && (r3_req == ACT_WRITE) &&
                  (32'(r3_x) < 32'(SRC_WIDTH)) && (32'(r3_y) < 32'(SRC_HEIGHT));
        n_waddr = {r3_y[YB:1], r3_x[XB:1]};
        for (int b = 0; b < 4; b++) begin
            n_we[b] = en && n_wr_ok && ({r3_y[0], r3_x[0]} == 2'(b));
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        awi_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (n_we[g]),
            .i_waddr (n_waddr),
            .i_wdata (r3_pix),
            .i_re    (en),
            .i_raddr (n_raddr[g]),
            .o_rdata (w_rdata[g])
        );
    end

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            n_wx = (r4_ix0 != b[0]) ? {1'b0, r4_fx} : ONE_Q16 - {1'b0, r4_fx};
            n_wy = (r4_iy0 != b[1]) ? {1'b0, r4_fy} : ONE_Q16 - {1'b0, r4_fy};
            if (!r4_inside) begin
                n_w[b] = '0;
            end else if (r_mode == MODE_NEAREST) begin
                n_w[b] = (r4_near == 2'(b)) ? WGT_ONE : '0;
            end else begin
                n_w[b] = WGT_W'(n_wx * n_wy);
            end
            n_pix[b] = (r4_zero[b] || (n_w[b] == '0)) ? '0 : w_rdata[b];
        end
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = (MUL_W+2)'(r6_prod[0][c]) + (MUL_W+2)'(r6_prod[1][c]) +
                       (MUL_W+2)'(r6_prod[2][c]) + (MUL_W+2)'(r6_prod[3][c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r_ov <= r6_v && (r6_req == ACT_REQUEST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_req <= i_action;
            r1_x   <= i_pos_x;
            r1_y   <= i_pos_y;
            r1_pix <= {i_in_red, i_in_green, i_in_blue};

            r2_req <= r1_req;
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_pix <= r1_pix;
            r2_pxx <= PROD_W'(r_coef_xx * $signed({1'b0, r1_x}));
            r2_pxy <= PROD_W'(r_coef_xy * $signed({1'b0, r1_y}));
            r2_pyx <= PROD_W'(r_coef_yx * $signed({1'b0, r1_x}));
            r2_pyy <= PROD_W'(r_coef_yy * $signed({1'b0, r1_y}));

            r3_req <= r2_req;
            r3_x   <= r2_x;
            r3_y   <= r2_y;
            r3_pix <= r2_pix;
            r3_sx  <= ACC_W'(r2_pxx) + ACC_W'(r2_pxy) + ACC_W'(r_offset_x);
            r3_sy  <= ACC_W'(r2_pyx) + ACC_W'(r2_pyy) + ACC_W'(r_offset_y);

            r4_req    <= r3_req;
            r4_inside <= n_inside;
            r4_ix0    <= n_ix[0];
            r4_iy0    <= n_iy[0];
            r4_fx     <= r3_sx[FRAC_BITS-1:0];
            r4_fy     <= r3_sy[FRAC_BITS-1:0];
            r4_zero   <= n_zero;
            r4_near   <= {n_iy[0] ^ (r3_sy[FRAC_BITS-1:0] > HALF_Q16),
                          n_ix[0] ^ (r3_sx[FRAC_BITS-1:0] > HALF_Q16)};

            r5_req    <= r4_req;
            r5_inside <= r4_inside;
            for (int b = 0; b < 4; b++) begin
                r5_w[b]   <= n_w[b];
                r5_pix[b] <= n_pix[b];
            end

            r6_req    <= r5_req;
            r6_inside <= r5_inside;
            for (int b = 0; b < 4; b++) begin
                for (int c = 0; c < 3; c++) begin
                    r6_prod[b][c] <= MUL_W'(r5_w[b] * r5_pix[b][(2-c)*CHAN_W +: CHAN_W]);
                end
            end

            r_oinside <= r6_inside;
            r_ored    <= n_sum[0][2*FRAC_BITS +: CHAN_W];
            r_ogreen  <= n_sum[1][2*FRAC_BITS +: CHAN_W];
            r_oblue   <= n_sum[2][2*FRAC_BITS +: CHAN_W];
        end
    end

    assign o_valid      = r_ov;
    assign o_inside_res = r_oinside;
    assign o_out_red    = r_ored;
    assign o_out_green  = r_ogreen;
    assign o_out_blue   = r_oblue;

    a_outside_black : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_inside_res) |-> (o_out_red == '0 && o_out_green == '0 &&
                                         o_out_blue == '0))
        else $error("outside point produced a nonzero color");

    a_weights_unity : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r5_v && r5_req == ACT_REQUEST && r5_inside) |->
        ((WGT_W+2)'(r5_w[0]) + (WGT_W+2)'(r5_w[1]) + (WGT_W+2)'(r5_w[2]) +
         (WGT_W+2)'(r5_w[3]) == (WGT_W+2)'(WGT_ONE)))
        else $error("sample weights do not sum to one");

    a_write_quiet_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> (n_we == 4'b0000))
        else $error("frame store written while pipeline is frozen");

endmodule

// ===== hdl/awi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module awi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/affine_warp_interpolator_checker.sv =====
// ----------------------------------------------------------------------------
// Affine warp interpolator checker
// Watches the request, result and register ports of the core, keeps its own
// copy of the frame store and the matrix, predicts every result at request
// acceptance and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module affine_warp_interpolator_checker
    import awi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_stall,
    input  logic                  i_action,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [CHAN_W-1:0]     i_in_red,
    input  logic [CHAN_W-1:0]     i_in_green,
    input  logic [CHAN_W-1:0]     i_in_blue,
    input  logic                  o_valid,
    input  logic                  i_stall,
    input  logic [CHAN_W-1:0]     o_out_red,
    input  logic [CHAN_W-1:0]     o_out_green,
    input  logic [CHAN_W-1:0]     o_out_blue,
    input  logic                  o_inside_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = DEF_SRC_WIDTH;
    localparam int H = DEF_SRC_HEIGHT;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              in_image;
    } t_pixel_result;

    logic [PIX_W-1:0] shadow_store [W*H];
    longint m_xx, m_xy, m_ox, m_yx, m_yy, m_oy;
    t_mode  sample_mode;
    t_pixel_result expected_pixels [$];

    function automatic logic [PIX_W-1:0] fetch(longint x, longint y);
        if (x >= W || y >= H) begin
            return '0;
        end
        return shadow_store[y*W + x];
    endfunction

    function automatic longint chan(logic [PIX_W-1:0] p, int c);
        return longint'(p[PIX_W-1-CHAN_W*c -: CHAN_W]);
    endfunction

    function automatic t_pixel_result warp_sample(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        t_pixel_result r;
        longint sx, sy, ix, iy, fx, fy, acc;
        logic [PIX_W-1:0] p00, p10, p01, p11, p;
        logic [CHAN_W-1:0] v [3];
        sx = m_xx * longint'(x) + m_xy * longint'(y) + m_ox;
        sy = m_yx * longint'(x) + m_yy * longint'(y) + m_oy;
        r = '0;
        if (sx < 0 || sy < 0 || sx >= (longint'(W) << FRAC_BITS) ||
                sy >= (longint'(H) << FRAC_BITS)) begin
            return r;
        end
        ix = sx >>> FRAC_BITS;
        iy = sy >>> FRAC_BITS;
        fx = sx & 64'hFFFF;
        fy = sy & 64'hFFFF;
        if (fx == 0 && fy == 0) begin
            p = fetch(ix, iy);
            for (int c = 0; c < 3; c++) v[c] = CHAN_W'(chan(p, c));
        end else if (sample_mode == MODE_NEAREST) begin
            p = fetch(ix + (fx > 32768 ? 1 : 0), iy + (fy > 32768 ? 1 : 0));
            for (int c = 0; c < 3; c++) v[c] = CHAN_W'(chan(p, c));
        end else begin
            p00 = fetch(ix, iy);
            p10 = fetch(ix + 1, iy);
            p01 = fetch(ix, iy + 1);
            p11 = fetch(ix + 1, iy + 1);
            for (int c = 0; c < 3; c++) begin
                acc = (65536 - fx) * (65536 - fy) * chan(p00, c) +
                      fx * (65536 - fy) * chan(p10, c) +
                      (65536 - fx) * fy * chan(p01, c) +
                      fx * fy * chan(p11, c);
                v[c] = CHAN_W'(acc >> 32);
            end
        end
        r.red = v[0];
        r.green = v[1];
        r.blue = v[2];
        r.in_image = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_result got, want;
        if (!i_rst_n) begin
            m_xx <= 65536;
            m_xy <= 0;
            m_ox <= 0;
            m_yx <= 0;
            m_yy <= 65536;
            m_oy <= 0;
            sample_mode <= MODE_BILINEAR;
            expected_pixels.delete();
            o_fail_count <= 0;
            o_checked <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_COEF_XX:  m_xx <= longint'($signed(i_cfg_data[COEF_W-1:0]));
                    CFG_COEF_XY:  m_xy <= longint'($signed(i_cfg_data[COEF_W-1:0]));
                    CFG_OFFSET_X: m_ox <= longint'($signed(i_cfg_data));
                    CFG_COEF_YX:  m_yx <= longint'($signed(i_cfg_data[COEF_W-1:0]));
                    CFG_COEF_YY:  m_yy <= longint'($signed(i_cfg_data[COEF_W-1:0]));
                    CFG_OFFSET_Y: m_oy <= longint'($signed(i_cfg_data));
                    CFG_MODE:     sample_mode <= t_mode'(i_cfg_data[0]);
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                got = {o_out_red, o_out_green, o_out_blue, o_inside_res};
                o_checked <= o_checked + 1;
                if (expected_pixels.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("Unexpected result rgb=%h inside=%b",
                                 got[24:1], got.in_image);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10) begin
                            $display({"Mismatch: expected r=%h g=%h b=%h in=%b, ",
                                      "got r=%h g=%h b=%h in=%b"},
                                want.red, want.green, want.blue, want.in_image,
                                got.red, got.green, got.blue, got.in_image);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                if (t_action'(i_action) == ACT_WRITE) begin
                    if (i_pos_x < W && i_pos_y < H) begin
                        shadow_store[i_pos_y*W + i_pos_x] = {i_in_red, i_in_green, i_in_blue};
                    end
                end else begin
                    expected_pixels.push_back(warp_sample(i_pos_x, i_pos_y));
                end
            end
        end
    end

    assign o_pending = expected_pixels.size();

endmodule

// ===== bench/affine_warp_interpolator_core_tb.sv =====
// ----------------------------------------------------------------------------
// Affine warp interpolator testbench
// Drives pixel writes and warp requests through several matrix settings and
// both sampling modes with random idling and stalls, writing every source
// pixel a request will touch before that request, and reports the verdict.
// ----------------------------------------------------------------------------
module affine_warp_interpolator_core_tb;
    import awi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = DEF_SRC_WIDTH;
    localparam int H = DEF_SRC_HEIGHT;
    localparam int CYCLE_LIMIT = 600000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_action = 1'b0;
    logic [POS_W-1:0]      i_pos_x = '0;
    logic [POS_W-1:0]      i_pos_y = '0;
    logic [CHAN_W-1:0]     i_in_red = '0;
    logic [CHAN_W-1:0]     i_in_green = '0;
    logic [CHAN_W-1:0]     i_in_blue = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [CHAN_W-1:0]     o_out_red;
    logic [CHAN_W-1:0]     o_out_green;
    logic [CHAN_W-1:0]     o_out_blue;
    logic                  o_inside_res;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count, pending, checked;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;
    int cycles = 0;
    int writes_sent = 0;
    int requests_sent = 0;
    bit written [W*H];
    longint m_xx = 65536, m_xy = 0, m_ox = 0, m_yx = 0, m_yy = 65536, m_oy = 0;
    t_mode sample_mode = MODE_BILINEAR;

    affine_warp_interpolator_core i_dut (.*);

    affine_warp_interpolator_checker i_checker (
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_checked(checked),
        .*
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_stall = 1'b1;
            hold_off = hold_off - 1;
        end else begin
            i_stall = ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send(t_action act, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                        logic [PIX_W-1:0] rgb);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_action = act;
        i_pos_x = x;
        i_pos_y = y;
        {i_in_red, i_in_green, i_in_blue} = rgb;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (act == ACT_WRITE) begin
            writes_sent++;
            if (x < W && y < H) written[y*W + x] = 1'b1;
        end else begin
            requests_sent++;
        end
    endtask

    task automatic touch(longint x, longint y);
        if (x < W && y < H && !written[y*W + x]) begin
            send(ACT_WRITE, POS_W'(x), POS_W'(y), PIX_W'($urandom()));
        end
    endtask

    // The source pixels a request reads are written first.
    task automatic request(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        longint sx, sy, ix, iy, fx, fy;
        sx = m_xx * longint'(x) + m_xy * longint'(y) + m_ox;
        sy = m_yx * longint'(x) + m_yy * longint'(y) + m_oy;
        if (sx >= 0 && sy >= 0 && sx < (longint'(W) << FRAC_BITS) &&
                sy < (longint'(H) << FRAC_BITS)) begin
            ix = sx >>> FRAC_BITS;
            iy = sy >>> FRAC_BITS;
            fx = sx & 64'hFFFF;
            fy = sy & 64'hFFFF;
            if (fx == 0 && fy == 0) begin
                touch(ix, iy);
            end else if (sample_mode == MODE_NEAREST) begin
                touch(ix + (fx > 32768 ? 1 : 0), iy + (fy > 32768 ? 1 : 0));
            end else begin
                touch(ix, iy);
                touch(ix + 1, iy);
                touch(ix, iy + 1);
                touch(ix + 1, iy + 1);
            end
        end
        send(ACT_REQUEST, x, y, PIX_W'($urandom()));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic reg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_COEF_XX:  m_xx = longint'($signed(d[COEF_W-1:0]));
            CFG_COEF_XY:  m_xy = longint'($signed(d[COEF_W-1:0]));
            CFG_OFFSET_X: m_ox = longint'($signed(d));
            CFG_COEF_YX:  m_yx = longint'($signed(d[COEF_W-1:0]));
            CFG_COEF_YY:  m_yy = longint'($signed(d[COEF_W-1:0]));
            CFG_OFFSET_Y: m_oy = longint'($signed(d));
            CFG_MODE:     sample_mode = t_mode'(d[0]);
            default: ;
        endcase
    endtask

    task automatic set_matrix(int xx, int xy, int ox, int yx, int yy, int oy, t_mode md);
        reg_write(CFG_COEF_XX, xx);
        reg_write(CFG_COEF_XY, xy);
        reg_write(CFG_OFFSET_X, ox);
        reg_write(CFG_COEF_YX, yx);
        reg_write(CFG_COEF_YY, yy);
        reg_write(CFG_OFFSET_Y, oy);
        reg_write(CFG_MODE, md);
    endtask

    function automatic int near_coef();
        return int'($urandom_range(131072)) - 65536;
    endfunction

    initial begin
        int xx, xy, ox, yx, yy, oy;
        t_mode md;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Field extremes and the corners of the image.
        send(ACT_WRITE, 0, 0, 24'h000000);
        send(ACT_WRITE, W-1, H-1, 24'hFFFFFF);
        send(ACT_WRITE, 12'hFFF, 12'hFFF, 24'hFFFFFF);
        send(ACT_WRITE, W, 0, 24'h123456);
        request(0, 0);
        request(W-1, H-1);
        request(12'hFFF, 12'hFFF);
        request(W, 3);
        drain();
        // Half-pixel shift reaches the right and bottom borders.
        set_matrix(65536, 0, 32768, 0, 65536, 32768, MODE_BILINEAR);
        request(5, 7);
        request(W-1, H-1);
        request(W-1, 0);
        drain();
        reg_write(CFG_MODE, MODE_NEAREST);
        request(5, 7);
        request(W-1, H-1);
        drain();
        reg_write(CFG_OFFSET_X, 32769);
        request(9, 9);
        request(W-1, 2);
        drain();
        set_matrix(65536, 0, -1, 0, 65536, 0, MODE_BILINEAR);
        request(0, 4);
        request(1, 4);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            md = t_mode'($urandom_range(1));
            case (phase % 6)
                0: set_matrix(65536, 0, 0, 0, 65536, 0, md);
                1: set_matrix(32768, 0, $urandom_range(32 << 16), 0, 40000,
                              $urandom_range(32 << 16), md);
                2: set_matrix(8388607, -8388608, 32'h7FFFFFFF, -8388608, 8388607,
                              32'h80000000, md);
                3: set_matrix(-8388608, 8388607, 32'h80000000, 8388607, -8388608,
                              32'h7FFFFFFF, md);
                default: begin
                    xx = near_coef();
                    xy = near_coef();
                    yx = near_coef();
                    yy = near_coef();
                    ox = int'($urandom_range(128 << 16)) - xx * 64 - xy * 64;
                    oy = int'($urandom_range(128 << 16)) - yx * 64 - yy * 64;
                    set_matrix(xx, xy, ox, yx, yy, oy, md);
                end
            endcase
            if (phase == 2 || phase == 7) hold_off = 300;
            for (int n = 0; n < 65; n++) begin
                if ($urandom_range(99) < 25) begin
                    send(ACT_WRITE, POS_W'($urandom()), POS_W'($urandom()),
                         PIX_W'($urandom()));
                end else if ($urandom_range(99) < 80) begin
                    request(POS_W'($urandom_range(W-1)), POS_W'($urandom_range(H-1)));
                end else begin
                    request(POS_W'($urandom()), POS_W'($urandom()));
                end
            end
            drain();
        end

        $display("Sent %0d pixel writes and %0d warp requests over 12 matrix settings.",
                 writes_sent, requests_sent);
        $display("Checked %0d results in both sampling modes.", checked);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
